// File: rtl/cire_pkg.sv
package cire_pkg;

    localparam int ID_BITS       = 31;
    localparam int TAG_BITS      = 3;
    localparam int WORD_BITS     = 32;
    localparam int NUM_OUT       = 4;
    localparam int SLOT_BITS     = $clog2(NUM_OUT);
    localparam int CNT_BITS      = $clog2(NUM_OUT + 1);
    localparam int EXT_BITS      = ID_BITS + WORD_BITS;
    localparam int RUN_MIN_EXTRA = 2;

    typedef logic [ID_BITS-1:0]   t_id;
    typedef logic [TAG_BITS-1:0]  t_tag;
    typedef logic [WORD_BITS-1:0] t_code;
    typedef logic [EXT_BITS-1:0]  t_ext;
    typedef logic [CNT_BITS-1:0]  t_cnt;
    typedef logic [SLOT_BITS-1:0] t_slot;

    // largest count word: positive full range of a signed word
    localparam t_ext COUNT_MAX = EXT_BITS'({1'b0, {(WORD_BITS-1){1'b1}}});

    typedef struct packed {
        t_id  first;
        t_id  extra;
        logic open;
        t_tag tag;
    } t_run;

    typedef struct packed {
        t_code code;
        t_tag  tag;
        logic  step_last;
        logic  list_done;
    } t_word;

    typedef struct packed {
        logic [1:0] cnt;
        t_code      w0;
        t_code      w1;
    } t_flush;

    function automatic t_ext id_ext(t_id v);
        return EXT_BITS'(v);
    endfunction

    // words for a closing run: one or two plain ids, or negated start + extra count
    function automatic t_flush run_flush(t_id first, t_id extra);
        t_flush f;
        t_ext   fe;
        t_ext   xe;
        t_ext   neg;
        t_ext   inc;
        fe  = id_ext(first);
        xe  = id_ext(extra);
        neg = t_ext'(0) - fe;
        inc = fe + t_ext'(1);
        if (xe >= t_ext'(RUN_MIN_EXTRA)) begin
            f.cnt = 2'd2;
            f.w0  = neg[WORD_BITS-1:0];
            f.w1  = (xe > COUNT_MAX) ? COUNT_MAX[WORD_BITS-1:0] : xe[WORD_BITS-1:0];
        end else begin
            f.cnt = (extra == t_id'(1)) ? 2'd2 : 2'd1;
            f.w0  = fe[WORD_BITS-1:0];
            f.w1  = inc[WORD_BITS-1:0];
        end
        return f;
    endfunction

endpackage

// File: rtl/cire_in_if.sv
interface cire_in_if;
    import cire_pkg::*;

    logic valid;
    logic ready;
    t_id  element_id;
    logic list_end;
    t_tag target_array;

    modport source (output valid, output element_id, output list_end,
                    output target_array, input ready);
    modport sink   (input valid, input element_id, input list_end,
                    input target_array, output ready);
endinterface

// File: rtl/cire_out_if.sv
interface cire_out_if;
    import cire_pkg::*;

    logic        valid;
    logic        ready;
    logic signed [WORD_BITS-1:0] code_word;
    t_tag        target_tag;
    logic        step_last;
    logic        list_done;

    modport source (output valid, output code_word, output target_tag,
                    output step_last, output list_done, input ready);
    modport sink   (input valid, input code_word, input target_tag,
                    input step_last, input list_done, output ready);
endinterface

// File: rtl/consecutive_id_run_encoder.sv
// channel  dir  payload                                         transfer
// i_in     in   element_id, list_end, target_array              valid & ready
// o_out    out  code_word, target_tag, step_last, list_done     valid & ready
//
// An accepted id sits in an input register, is encoded combinationally into a
// result buffer of up to four words, and the words leave one per cycle while
// the output is ready. A new id loads as the buffer empties; the single output
// word per cycle of the result buffer sets the rate.
// Synchronous active-low reset clears the open run and both buffers.
// A stalled output holds the buffer; one more id waits in the input register.
module consecutive_id_run_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cire_in_if.sink    i_in,
    cire_out_if.source o_out
);
    import cire_pkg::*;

    t_run                r_run;
    logic                r_in_valid;
    t_id                 r_in_id;
    logic                r_in_last;
    t_tag                r_in_tag;
    t_cnt                r_cnt;
    t_word [NUM_OUT-1:0] r_slot;

    t_run                n_run;
    t_cnt                n_cnt;
    t_word [NUM_OUT-1:0] n_words;

    logic pop;
    logic load;
    logic in_take;

    cire_encode u_encode (
        .i_run   (r_run),
        .i_id    (r_in_id),
        .i_last  (r_in_last),
        .i_tag   (r_in_tag),
        .o_run   (n_run),
        .o_cnt   (n_cnt),
        .o_words (n_words)
    );

    assign pop     = (r_cnt != '0) && o_out.ready;
    // buffer frees up when empty or when its last word leaves now
    assign load    = r_in_valid && ((r_cnt == '0) || ((r_cnt == t_cnt'(1)) && pop));
    assign in_take = i_in.valid && i_in.ready;

    assign i_in.ready = !r_in_valid || load;

    assign o_out.valid      = (r_cnt != '0);
    assign o_out.code_word  = r_slot[0].code;
    assign o_out.target_tag = r_slot[0].tag;
    assign o_out.step_last  = r_slot[0].step_last;
    assign o_out.list_done  = r_slot[0].list_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run      <= '0;
            r_in_valid <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
            if (load) begin
                r_run <= n_run;
                r_cnt <= n_cnt;
            end else if (pop) begin
                r_cnt <= r_cnt - t_cnt'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_id   <= i_in.element_id;
            r_in_last <= i_in.list_end;
            r_in_tag  <= i_in.target_array;
        end
        if (load) begin
            r_slot <= n_words;
        end else if (pop) begin
            for (int i = 0; i < NUM_OUT - 1; i++) begin
                r_slot[i] <= r_slot[i+1];
            end
        end
    end

endmodule

// File: rtl/cire_encode.sv
module cire_encode (
    input  cire_pkg::t_run                      i_run,
    input  cire_pkg::t_id                       i_id,
    input  logic                                i_last,
    input  cire_pkg::t_tag                      i_tag,
    output cire_pkg::t_run                      o_run,
    output cire_pkg::t_cnt                      o_cnt,
    output cire_pkg::t_word [cire_pkg::NUM_OUT-1:0] o_words
);
    import cire_pkg::*;

    t_ext   succ;
    logic   extend;
    t_flush fa;
    t_flush fb;
    t_run   mid;
    t_cnt   na;
    t_cnt   nb;
    t_cnt   ntot;
    t_slot  pos;
    t_slot  tail;

    always_comb begin
        succ   = id_ext(i_run.first) + id_ext(i_run.extra) + t_ext'(1);
        extend = i_run.open && (succ == id_ext(i_id)) && (i_run.extra != '1);

        // closing the old run when the id does not continue it
        fa = run_flush(i_run.first, i_run.extra);
        na = (i_run.open && !extend) ? CNT_BITS'(fa.cnt) : '0;

        if (extend) begin
            mid       = i_run;
            mid.extra = i_run.extra + t_id'(1);
        end else begin
            mid.first = i_id;
            mid.extra = '0;
            mid.open  = 1'b1;
            mid.tag   = i_tag;
        end

        // end of list flushes whatever run is open now
        fb = run_flush(mid.first, mid.extra);
        nb = i_last ? CNT_BITS'(fb.cnt) : '0;

        if (i_last) begin
            o_run       = '0;
            o_run.tag   = mid.tag;
        end else begin
            o_run = mid;
        end

        o_words = '0;
        for (int k = 0; k < 2; k++) begin
            if (CNT_BITS'(k) < na) begin
                o_words[k].code = (k == 0) ? fa.w0 : fa.w1;
                o_words[k].tag  = i_run.tag;
            end
        end
        for (int k = 0; k < 2; k++) begin
            pos = na[SLOT_BITS-1:0] + SLOT_BITS'(k);
            if (CNT_BITS'(k) < nb) begin
                o_words[pos].code = (k == 0) ? fb.w0 : fb.w1;
                o_words[pos].tag  = mid.tag;
            end
        end

        ntot = na + nb;
        o_cnt = ntot;
        tail = SLOT_BITS'(ntot - t_cnt'(1));
        if (ntot != '0) begin
            o_words[tail].step_last = 1'b1;
            o_words[tail].list_done = i_last;
        end
    end

endmodule

// File: rtl/cire_checker.sv
module cire_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic [cire_pkg::WORD_BITS-1:0] i_code_word,
    input cire_pkg::t_tag                i_target_tag,
    input logic                          i_step_last,
    input logic                          i_list_done
);
    import cire_pkg::*;

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> i_valid)
        else $error("output valid dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> ($stable(i_code_word) && $stable(i_target_tag)
            && $stable(i_step_last) && $stable(i_list_done)))
        else $error("output payload changed while stalled");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_list_done) |-> i_step_last)
        else $error("list end word not marked as last of its step");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_valid)
        else $error("result buffer not empty after reset");

endmodule

bind consecutive_id_run_encoder cire_checker u_cire_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_out.valid),
    .i_ready      (o_out.ready),
    .i_code_word  (o_out.code_word),
    .i_target_tag (o_out.target_tag),
    .i_step_last  (o_out.step_last),
    .i_list_done  (o_out.list_done)
);

// File: bench/consecutive_id_run_encoder_test.sv
module consecutive_id_run_encoder_test;
    import cire_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_IDS   = 385;
    localparam int SCRIPT_ROWS  = 25;
    localparam int SUCC_BITS    = ID_BITS + 2;
    localparam logic [15:0] STALL_PATTERN = 16'b0110_1110_0011_1011;

    // typed = number of words written out in the row, 0 = taken from encode_id
    typedef struct packed {
        t_id        id;
        logic       last;
        t_tag       tag;
        logic [1:0] typed;
        t_code      exp0;
        t_code      exp1;
        t_tag       exp_tag;
    } t_row;

    localparam t_row SCRIPT [SCRIPT_ROWS] = '{
        // lone ids at the extremes, each its own list
        '{31'd1,          1'b1, 3'd0, 2'd1, 32'd1,          32'd0,  3'd0},
        '{31'h7FFFFFFF,   1'b1, 3'd7, 2'd1, 32'h7FFFFFFF,   32'd0,  3'd7},
        '{31'd0,          1'b1, 3'd5, 2'd1, 32'd0,          32'd0,  3'd5},
        // run of three, tag moves inside the run
        '{31'd10,         1'b0, 3'd2, 2'd0, 32'd0,          32'd0,  3'd0},
        '{31'd11,         1'b0, 3'd3, 2'd0, 32'd0,          32'd0,  3'd0},
        '{31'd12,         1'b1, 3'd4, 2'd2, 32'hFFFFFFF6,   32'd2,  3'd2},
        // run of two stays plain
        '{31'd20,         1'b0, 3'd1, 2'd0, 32'd0,          32'd0,  3'd0},
        '{31'd21,         1'b1, 3'd1, 2'd2, 32'd20,         32'd21, 3'd1},
        // descending and repeated ids break runs
        '{31'd100,        1'b0, 3'd6, 2'd0, 32'd0,          32'd0,  3'd0},
        '{31'd101,        1'b0, 3'd6, 2'd0, 32'd0,          32'd0,  3'd0},
        '{31'd102,        1'b0, 3'd6, 2'd0, 32'd0,          32'd0,  3'd0},
        '{31'd50,         1'b0, 3'd6, 2'd0, 32'd0,          32'd0,  3'd0},
        '{31'd50,         1'b0, 3'd6, 2'd0, 32'd0,          32'd0,  3'd0},
        '{31'd51,         1'b0, 3'd6, 2'd0, 32'd0,          32'd0,  3'd0},
        '{31'd40,         1'b0, 3'd6, 2'd0, 32'd0,          32'd0,  3'd0},
        '{31'd41,         1'b0, 3'd6, 2'd0, 32'd0,          32'd0,  3'd0},
        '{31'd42,         1'b0, 3'd6, 2'd0, 32'd0,          32'd0,  3'd0},
        '{31'd43,         1'b1, 3'd6, 2'd2, 32'hFFFFFFD8,   32'd3,  3'd6},
        // closing a long run and flushing a new one in the same id: three words
        '{31'd200,        1'b0, 3'd3, 2'd0, 32'd0,          32'd0,  3'd0},
        '{31'd201,        1'b0, 3'd3, 2'd0, 32'd0,          32'd0,  3'd0},
        '{31'd202,        1'b0, 3'd3, 2'd0, 32'd0,          32'd0,  3'd0},
        '{31'd7,          1'b1, 3'd0, 2'd0, 32'd0,          32'd0,  3'd0},
        // run up to the top id
        '{31'h7FFFFFFD,   1'b0, 3'd5, 2'd0, 32'd0,          32'd0,  3'd0},
        '{31'h7FFFFFFE,   1'b0, 3'd5, 2'd0, 32'd0,          32'd0,  3'd0},
        '{31'h7FFFFFFF,   1'b1, 3'd5, 2'd2, 32'h80000003,   32'd2,  3'd5}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    cire_in_if  in_ch ();
    cire_out_if out_ch ();

    consecutive_id_run_encoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // encoder state kept by the bench
    t_id   run_first = '0;
    t_id   run_extra = '0;
    logic  run_open  = 1'b0;
    t_tag  run_tag   = '0;
    t_word step_words [NUM_OUT];
    int    step_count;

    t_word words_due [$];
    t_word got_word;
    t_word want_word;
    int    mismatch_count = 0;
    int    cycle_count    = 0;
    int    ready_cycle    = 0;
    int    burst_left     = 0;

    function automatic void emit_word(t_code code);
        step_words[step_count].code      = code;
        step_words[step_count].tag       = run_tag;
        step_words[step_count].step_last = 1'b0;
        step_words[step_count].list_done = 1'b0;
        step_count++;
    endfunction

    function automatic void close_run();
        if (run_extra >= t_id'(RUN_MIN_EXTRA)) begin
            emit_word(t_code'(0) - t_code'(run_first));
            // extra count is ID_BITS wide, so it never passes the positive word limit
            emit_word(t_code'(run_extra));
        end else begin
            emit_word(t_code'(run_first));
            if (run_extra == t_id'(1))
                emit_word(t_code'(run_first) + t_code'(1));
        end
    endfunction

    function automatic void encode_id(t_id id, logic last, t_tag tag);
        logic [SUCC_BITS-1:0] successor;
        successor  = {2'b00, run_first} + {2'b00, run_extra} + 1'b1;
        step_count = 0;
        if (run_open && successor == {2'b00, id} && run_extra != '1) begin
            run_extra++;
        end else begin
            if (run_open)
                close_run();
            run_first = id;
            run_extra = '0;
            run_tag   = tag;
            run_open  = 1'b1;
        end
        if (last) begin
            close_run();
            run_open  = 1'b0;
            run_first = '0;
            run_extra = '0;
            step_words[step_count-1].list_done = 1'b1;
        end
        if (step_count > 0)
            step_words[step_count-1].step_last = 1'b1;
    endfunction

    function automatic void queue_step_words();
        for (int k = 0; k < step_count; k++)
            words_due.insert(words_due.size(), step_words[k]);
    endfunction

    function automatic void check_field(string what, t_code want, t_code got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    // one id transfer; the sender may idle between bursts of random length
    task automatic send_id(t_id id, logic last, t_tag tag);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid        <= 1'b1;
        in_ch.element_id   <= id;
        in_ch.list_end     <= last;
        in_ch.target_array <= tag;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        burst_left--;
    endtask

    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (words_due.size() != 0)
            @(posedge i_clk);
        burst_left = 0;
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // output side: check every transfer; ready rotates through always ready, random, a fixed stall pattern, random
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got_word.code      = out_ch.code_word;
            got_word.tag       = out_ch.target_tag;
            got_word.step_last = out_ch.step_last;
            got_word.list_done = out_ch.list_done;
            if (words_due.size() == 0) begin
                $display("%0t: word with none expected: expected nothing got %h",
                         $time, got_word);
                mismatch_count++;
            end else begin
                want_word = words_due.pop_front();
                check_field("code_word", want_word.code, got_word.code);
                check_field("target_tag", t_code'(want_word.tag), t_code'(got_word.tag));
                check_field("step_last", t_code'(want_word.step_last),
                            t_code'(got_word.step_last));
                check_field("list_done", t_code'(want_word.list_done),
                            t_code'(got_word.list_done));
            end
        end
        ready_cycle++;
        case ((ready_cycle / 256) % 4)
            0: begin
                out_ch.ready <= 1'b1;
            end
            1: begin
                out_ch.ready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                out_ch.ready <= STALL_PATTERN[ready_cycle % 16];
            end
            default: begin
                out_ch.ready <= ($urandom_range(0, 9) > 6);
            end
        endcase
    end

    initial begin
        t_row row;
        t_id  id;
        t_tag tag;
        int   list_len;
        int   sent;
        int   pick;
        logic last;

        in_ch.valid        = 1'b0;
        in_ch.element_id   = '0;
        in_ch.list_end     = 1'b0;
        in_ch.target_array = '0;
        out_ch.ready       = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < SCRIPT_ROWS; r++) begin
            row = SCRIPT[r];
            send_id(row.id, row.last, row.tag);
            encode_id(row.id, row.last, row.tag);
            if (row.typed == 2'd0) begin
                queue_step_words();
            end else begin
                for (int k = 0; k < int'(row.typed); k++) begin
                    want_word.code      = (k == 0) ? row.exp0 : row.exp1;
                    want_word.tag       = row.exp_tag;
                    want_word.step_last = (k == int'(row.typed) - 1);
                    want_word.list_done = (k == int'(row.typed) - 1);
                    words_due.insert(words_due.size(), want_word);
                end
            end
        end
        hold_until_drained();

        // random lists: mostly ascending with runs, some gaps, repeats and strays
        sent = 0;
        while (sent < RANDOM_IDS) begin
            list_len = $urandom_range(1, 12);
            tag      = t_tag'($urandom_range(0, 7));
            pick     = $urandom_range(0, 9);
            if (pick < 5)
                id = t_id'($urandom_range(1, 1000));
            else if (pick < 9)
                id = t_id'($urandom_range(32'h7FFFFFFF, 1));
            else
                id = t_id'(31'h7FFFFFFF - $urandom_range(0, 12));
            for (int i = 0; i < list_len; i++) begin
                last = (i == list_len - 1) || ($urandom_range(0, 39) == 0);
                if ($urandom_range(0, 19) == 0)
                    tag = t_tag'($urandom_range(0, 7));
                send_id(id, last, tag);
                encode_id(id, last, tag);
                queue_step_words();
                sent++;
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    id = id + t_id'(1);
                else if (pick < 80)
                    id = id + t_id'($urandom_range(2, 6));
                else if (pick < 92)
                    id = id - t_id'($urandom_range(0, 3));
                else
                    id = t_id'($urandom);
            end
            if ($urandom_range(0, 7) == 0)
                hold_until_drained();
        end

        in_ch.valid <= 1'b0;
        while (words_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && words_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/cire_pkg.sv
rtl/cire_in_if.sv
rtl/cire_out_if.sv
rtl/cire_encode.sv
rtl/consecutive_id_run_encoder.sv
rtl/cire_checker.sv
bench/consecutive_id_run_encoder_test.sv
